>>> rtl/acjl_pkg.sv
package acjl_pkg;

  localparam int DataW    = 24;
  localparam int IvlW     = 16;
  localparam int LimW     = 23;
  localparam int ProdW    = 48;
  localparam int RootW    = 24;
  localparam int QuotW    = 23;
  localparam int SqrtSteps = 24;
  localparam int DivSteps  = 23;
  localparam int CntW     = 5;
  localparam int AddrW    = 5;
  localparam int PDataW   = 32;

  // register indexes
  localparam logic [2:0] REG_STEP_INTERVAL = 3'd0;
  localparam logic [2:0] REG_JERK_LIMIT    = 3'd1;
  localparam logic [2:0] REG_HORIZ_LIMIT   = 3'd2;
  localparam logic [2:0] REG_VERT_LIMIT    = 3'd3;
  localparam logic [2:0] REG_YAW_LIMIT     = 3'd4;

  localparam logic [IvlW-1:0] STEP_INTERVAL_RST = 16'd6554;
  localparam logic [LimW-1:0] JERK_LIMIT_RST    = 23'd1310720;
  localparam logic [LimW-1:0] HORIZ_LIMIT_RST   = 23'd327680;
  localparam logic [LimW-1:0] VERT_LIMIT_RST    = 23'd196608;
  localparam logic [LimW-1:0] YAW_LIMIT_RST     = 23'd131072;

  typedef enum logic [2:0] {
    MUL_DELTA = 3'd0,
    MUL_XX    = 3'd1,
    MUL_YY    = 3'd2,
    MUL_HH    = 3'd3,
    MUL_XH    = 3'd4,
    MUL_YH    = 3'd5
  } mul_sel_t;

  typedef struct packed {
    logic [IvlW-1:0] step_interval;
    logic [LimW-1:0] jerk_limit;
    logic [LimW-1:0] horiz_limit;
    logic [LimW-1:0] vert_limit;
    logic [LimW-1:0] yaw_limit;
  } cfg_t;

  typedef struct packed {
    logic     capture;
    logic     start;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     delta_ld;
    logic     sq_ld;
    logic     sq_add;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     m_ld;
    logic     div_init;
    logic     div_step;
    logic     rx_ld;
    logic     ry_ld;
    logic     fin;
  } dp_cmd_t;

  typedef struct packed {
    logic over;
  } dp_stat_t;

endpackage

>>> rtl/acceleration_jerk_limiter.sv
// A start item is absorbed in its accept cycle and gives no result.
// A command item skips the square root and divisions when the horizontal vector is
// inside its limit; when it is scaled, a 24-step square root and two 23-step divisions
// run one bit a cycle, the two divisions on one shared divider.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (rst, synchronous): limits and step interval to defaults, priors and start interval zero.
module acceleration_jerk_limiter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // accel_x[23:0], accel_y[47:24], accel_z[71:48], accel_yaw[95:72], interval[111:96]
  input  logic [111:0]                 s_tdata,
  // cmd[0]
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // out_x[23:0], out_y[47:24], out_z[71:48], out_yaw[95:72]
  output logic [95:0]                  m_tdata,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [acjl_pkg::AddrW-1:0]   paddr,
  input  logic [acjl_pkg::PDataW-1:0]  pwdata,
  output logic [acjl_pkg::PDataW-1:0]  prdata,
  output logic                         pready
);

  acjl_pkg::cfg_t     cfg;
  acjl_pkg::dp_cmd_t  cmd;
  acjl_pkg::dp_stat_t stat;
  logic signed [acjl_pkg::DataW-1:0] out_x, out_y, out_z, out_yaw;

  acjl_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  acjl_ctrl u_ctrl (
    .clk, .rst,
    .in_valid  (s_tvalid),
    .in_cmd    (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat, .cmd
  );

  acjl_dpath u_dpath (
    .clk, .rst, .cfg, .cmd, .stat,
    .in_x        (s_tdata[23:0]),
    .in_y        (s_tdata[47:24]),
    .in_z        (s_tdata[71:48]),
    .in_yaw      (s_tdata[95:72]),
    .in_interval (s_tdata[111:96]),
    .out_x, .out_y, .out_z, .out_yaw
  );

  assign m_tdata = {out_yaw, out_z, out_y, out_x};

`ifndef SYNTHESIS
  // a command transaction occupies the block
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> !s_tready)
    else $error("command accepted without leaving idle");

  // a result appears only at the end of command processing
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while idle");

  // a start transaction produces no result
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser && !m_tvalid) |=> !m_tvalid)
    else $error("start produced a result");
`endif

endmodule

>>> rtl/acjl_regs.sv
module acjl_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [acjl_pkg::AddrW-1:0]   paddr,
  input  logic [acjl_pkg::PDataW-1:0]  pwdata,
  output logic [acjl_pkg::PDataW-1:0]  prdata,
  output logic                         pready,
  output acjl_pkg::cfg_t               cfg
);

  logic [2:0] index;
  logic       wr;

  assign index  = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // write the addressed register, ignore unknown addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_interval <= acjl_pkg::STEP_INTERVAL_RST;
      cfg.jerk_limit    <= acjl_pkg::JERK_LIMIT_RST;
      cfg.horiz_limit   <= acjl_pkg::HORIZ_LIMIT_RST;
      cfg.vert_limit    <= acjl_pkg::VERT_LIMIT_RST;
      cfg.yaw_limit     <= acjl_pkg::YAW_LIMIT_RST;
    end else if (wr) begin
      case (index)
        acjl_pkg::REG_STEP_INTERVAL: cfg.step_interval <= pwdata[15:0];
        acjl_pkg::REG_JERK_LIMIT:    cfg.jerk_limit    <= pwdata[22:0];
        acjl_pkg::REG_HORIZ_LIMIT:   cfg.horiz_limit   <= pwdata[22:0];
        acjl_pkg::REG_VERT_LIMIT:    cfg.vert_limit    <= pwdata[22:0];
        acjl_pkg::REG_YAW_LIMIT:     cfg.yaw_limit     <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (index)
      acjl_pkg::REG_STEP_INTERVAL: prdata = {16'd0, cfg.step_interval};
      acjl_pkg::REG_JERK_LIMIT:    prdata = {9'd0, cfg.jerk_limit};
      acjl_pkg::REG_HORIZ_LIMIT:   prdata = {9'd0, cfg.horiz_limit};
      acjl_pkg::REG_VERT_LIMIT:    prdata = {9'd0, cfg.vert_limit};
      acjl_pkg::REG_YAW_LIMIT:     prdata = {9'd0, cfg.yaw_limit};
      default:                     prdata = '0;
    endcase
  end

endmodule

>>> rtl/acjl_ctrl.sv
module acjl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_cmd,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  acjl_pkg::dp_stat_t  stat,
  output acjl_pkg::dp_cmd_t   cmd
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_MD   = 14'b00000000000010,
    S_MX   = 14'b00000000000100,
    S_MY   = 14'b00000000001000,
    S_MH   = 14'b00000000010000,
    S_CMP  = 14'b00000000100000,
    S_SQRT = 14'b00000001000000,
    S_MSX  = 14'b00000010000000,
    S_DXI  = 14'b00000100000000,
    S_DX   = 14'b00001000000000,
    S_DYI  = 14'b00010000000000,
    S_DY   = 14'b00100000000000,
    S_RY   = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } state_t;

  state_t                    state, state_next;
  logic [acjl_pkg::CntW-1:0] cnt, cnt_next;
  logic                      out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // sequence one command item through the shared multiplier, root and divider
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid & ~out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mul_sel    = acjl_pkg::MUL_DELTA;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_cmd) state_next = S_MD;
          else        cmd.start  = 1'b1;
        end
      end
      S_MD: begin
        cmd.mul_en = 1'b1;
        state_next = S_MX;
      end
      S_MX: begin
        cmd.delta_ld = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = acjl_pkg::MUL_XX;
        state_next   = S_MY;
      end
      S_MY: begin
        cmd.sq_ld   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = acjl_pkg::MUL_YY;
        state_next  = S_MH;
      end
      S_MH: begin
        cmd.sq_add  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = acjl_pkg::MUL_HH;
        state_next  = S_CMP;
      end
      S_CMP: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = '0;
        state_next    = stat.over ? S_SQRT : S_FIN;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == acjl_pkg::CntW'(acjl_pkg::SqrtSteps - 1)) state_next = S_MSX;
      end
      S_MSX: begin
        cmd.m_ld    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = acjl_pkg::MUL_XH;
        state_next  = S_DXI;
      end
      S_DXI: begin
        cmd.div_init = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = acjl_pkg::MUL_YH;
        cnt_next     = '0;
        state_next   = S_DX;
      end
      S_DX: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == acjl_pkg::CntW'(acjl_pkg::DivSteps - 1)) state_next = S_DYI;
      end
      S_DYI: begin
        cmd.rx_ld    = 1'b1;
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DY;
      end
      S_DY: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == acjl_pkg::CntW'(acjl_pkg::DivSteps - 1)) state_next = S_RY;
      end
      S_RY: begin
        cmd.ry_ld  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.fin        = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/acjl_dpath.sv
module acjl_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  acjl_pkg::cfg_t                     cfg,
  input  acjl_pkg::dp_cmd_t                  cmd,
  output acjl_pkg::dp_stat_t                 stat,
  input  logic signed [acjl_pkg::DataW-1:0]  in_x,
  input  logic signed [acjl_pkg::DataW-1:0]  in_y,
  input  logic signed [acjl_pkg::DataW-1:0]  in_z,
  input  logic signed [acjl_pkg::DataW-1:0]  in_yaw,
  input  logic        [acjl_pkg::IvlW-1:0]   in_interval,
  output logic signed [acjl_pkg::DataW-1:0]  out_x,
  output logic signed [acjl_pkg::DataW-1:0]  out_y,
  output logic signed [acjl_pkg::DataW-1:0]  out_z,
  output logic signed [acjl_pkg::DataW-1:0]  out_yaw
);

  localparam int DW = acjl_pkg::DataW;
  localparam int PW = acjl_pkg::ProdW;
  localparam int LW = acjl_pkg::LimW;
  localparam int RW = acjl_pkg::RootW;
  localparam int QW = acjl_pkg::QuotW;

  logic signed [DW-1:0]       ax, ay, az, ayaw;
  logic signed [DW-1:0]       prior_x, prior_y, prior_z;
  logic [acjl_pkg::IvlW-1:0]  start_interval;
  logic                       at_first_step;
  logic [LW-1:0]              delta;
  logic [PW-1:0]              prod, sq, rad;
  logic [RW-1:0]              root, m;
  logic [RW+1:0]              rem;
  logic [RW:0]                drem;
  logic [QW-1:0]              dlow, quot;
  logic signed [DW-1:0]       rx, ry;

  logic [DW-1:0]              abs_x, abs_y, mul_a, mul_b;
  logic [acjl_pkg::IvlW-1:0]  ivl;
  logic [RW+2:0]              t_rem, trial;
  logic [RW+1:0]              t_div;
  logic signed [DW-1:0]       qfix_x, qfix_y;

  assign abs_x = ax[DW-1] ? DW'(-ax) : ax;
  assign abs_y = ay[DW-1] ? DW'(-ay) : ay;
  assign ivl   = at_first_step ? start_interval : cfg.step_interval;
  assign stat.over = sq > prod;

  // select the shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      acjl_pkg::MUL_DELTA: begin
        mul_a = {1'b0, cfg.jerk_limit};
        mul_b = {8'd0, ivl};
      end
      acjl_pkg::MUL_XX: begin mul_a = abs_x; mul_b = abs_x; end
      acjl_pkg::MUL_YY: begin mul_a = abs_y; mul_b = abs_y; end
      acjl_pkg::MUL_HH: begin
        mul_a = {1'b0, cfg.horiz_limit};
        mul_b = {1'b0, cfg.horiz_limit};
      end
      acjl_pkg::MUL_XH: begin mul_a = abs_x; mul_b = {1'b0, cfg.horiz_limit}; end
      acjl_pkg::MUL_YH: begin mul_a = abs_y; mul_b = {1'b0, cfg.horiz_limit}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // one root digit and one quotient bit per step
  assign t_rem  = {rem[RW:0], rad[PW-1:PW-2]};
  assign trial  = {1'b0, root, 2'b01};
  assign t_div  = {drem, dlow[QW-1]};
  assign qfix_x = ax[DW-1] ? DW'(-{1'b0, quot}) : DW'({1'b0, quot});
  assign qfix_y = ay[DW-1] ? DW'(-{1'b0, quot}) : DW'({1'b0, quot});

  function automatic logic signed [DW-1:0] rate_lim(input logic signed [DW:0] v,
                                                    input logic signed [DW-1:0] p,
                                                    input logic [LW-1:0] d);
    logic signed [DW+1:0] lo, hi, c;
    lo = (DW+2)'(p) - $signed({3'b0, d});
    hi = (DW+2)'(p) + $signed({3'b0, d});
    c  = (DW+2)'(v);
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    if (c > (DW+2)'(2**(DW-1) - 1)) c = (DW+2)'(2**(DW-1) - 1);
    if (c < -(DW+2)'(2**(DW-1)))    c = -(DW+2)'(2**(DW-1));
    return c[DW-1:0];
  endfunction

  function automatic logic signed [DW:0] mag_clamp(input logic signed [DW-1:0] v,
                                                   input logic [LW-1:0] l);
    logic signed [DW:0] lim, c;
    lim = $signed({2'b0, l});
    c   = (DW+1)'(v);
    if (c > lim)  c = lim;
    if (c < -lim) c = -lim;
    return c;
  endfunction

  // control state: priors, first step flag
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_x        <= '0;
      prior_y        <= '0;
      prior_z        <= '0;
      start_interval <= '0;
      at_first_step  <= 1'b1;
    end else if (cmd.start) begin
      prior_x        <= in_x;
      prior_y        <= in_y;
      prior_z        <= in_z;
      start_interval <= in_interval;
      at_first_step  <= 1'b1;
    end else if (cmd.fin) begin
      prior_x        <= rate_lim((DW+1)'(rx), prior_x, delta);
      prior_y        <= rate_lim((DW+1)'(ry), prior_y, delta);
      prior_z        <= rate_lim(mag_clamp(az, cfg.vert_limit), prior_z, delta);
      at_first_step  <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ax   <= in_x;
      ay   <= in_y;
      az   <= in_z;
      ayaw <= in_yaw;
      rx   <= in_x;
      ry   <= in_y;
    end
    if (cmd.rx_ld)    rx <= qfix_x;
    if (cmd.ry_ld)    ry <= qfix_y;
    if (cmd.mul_en)   prod <= mul_a * mul_b;
    if (cmd.delta_ld) delta <= prod[LW+15:16];
    if (cmd.sq_ld)    sq <= prod;
    if (cmd.sq_add)   sq <= sq + prod;
    if (cmd.sqrt_init) begin
      rad  <= sq;
      root <= '0;
      rem  <= '0;
    end
    if (cmd.sqrt_step) begin
      rad <= {rad[PW-3:0], 2'b00};
      if (t_rem >= trial) begin
        rem  <= (RW+2)'(t_rem - trial);
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= t_rem[RW+1:0];
        root <= {root[RW-2:0], 1'b0};
      end
    end
    if (cmd.m_ld) m <= root + RW'(rem != '0);
    if (cmd.div_init) begin
      drem <= prod[PW-1:QW];
      dlow <= prod[QW-1:0];
      quot <= '0;
    end
    if (cmd.div_step) begin
      dlow <= {dlow[QW-2:0], 1'b0};
      if (t_div >= {2'b00, m}) begin
        drem <= (RW+1)'(t_div - {2'b00, m});
        quot <= {quot[QW-2:0], 1'b1};
      end else begin
        drem <= t_div[RW:0];
        quot <= {quot[QW-2:0], 1'b0};
      end
    end
    if (cmd.fin) begin
      out_x   <= rate_lim((DW+1)'(rx), prior_x, delta);
      out_y   <= rate_lim((DW+1)'(ry), prior_y, delta);
      out_z   <= rate_lim(mag_clamp(az, cfg.vert_limit), prior_z, delta);
      out_yaw <= DW'(mag_clamp(ayaw, cfg.yaw_limit));
    end
  end

endmodule
